@@ src/ght_pkg.sv @@
// ----------------------------------------------------------------------------
// ght_pkg
// Shared types and constants for the generational handle table: command and
// status codes, the input and result word layouts, and memory write controls.
// ----------------------------------------------------------------------------
`default_nettype none

package ght_pkg;

  localparam int unsigned SLOT_COUNT_DEF = 1024;
  localparam int unsigned HALF_W         = 16;
  localparam int unsigned RESULT_SLOT_W  = 10;

  typedef enum logic [1:0] {
    CMD_ADD    = 2'd0,
    CMD_REMOVE = 2'd1,
    CMD_LOOKUP = 2'd2,
    CMD_CLEAR  = 2'd3
  } ght_cmd_t;

  typedef enum logic [1:0] {
    ST_OK     = 2'd0,
    ST_BOUNDS = 2'd1,
    ST_STALE  = 2'd2,
    ST_FULL   = 2'd3
  } ght_status_t;

  typedef struct packed {
    logic [1:0]        command;
    logic [HALF_W-1:0] slot_index;
    logic [HALF_W-1:0] serial;
  } ght_in_t;

  typedef struct packed {
    logic [2*HALF_W-1:0]      handle;
    logic [RESULT_SLOT_W-1:0] result_slot;
    logic [1:0]               status;
  } ght_out_t;

  typedef struct packed {
    logic ser_we;
    logic link_we;
  } ght_wr_ctl_t;

endpackage

`default_nettype wire

@@ src/ght_slot_store.sv @@
// ----------------------------------------------------------------------------
// ght_slot_store
// Per-slot serial and free-list link memories with a registered read port.
// A write to the address being read in the same cycle is forwarded.
// ----------------------------------------------------------------------------
`default_nettype none

module ght_slot_store #(
  parameter int unsigned SLOT_COUNT = ght_pkg::SLOT_COUNT_DEF,
  localparam int unsigned IDX_W     = $clog2(SLOT_COUNT),
  localparam int unsigned HEAD_W    = $clog2(SLOT_COUNT + 1)
) (
  input  wire logic                    clk,
  input  wire logic                    rd_en,
  input  wire logic [IDX_W-1:0]        rd_addr,
  input  wire ght_pkg::ght_wr_ctl_t    wr_ctl,
  input  wire logic [IDX_W-1:0]        wr_addr,
  input  wire logic [ght_pkg::HALF_W-1:0] wr_ser,
  input  wire logic [HEAD_W-1:0]       wr_link,
  output logic [ght_pkg::HALF_W-1:0]   rd_ser,
  output logic [HEAD_W-1:0]            rd_link
);

  logic [ght_pkg::HALF_W-1:0] ser_mem [SLOT_COUNT];
  logic [HEAD_W-1:0]          link_mem [SLOT_COUNT];

  logic [ght_pkg::HALF_W-1:0] ser_q_r;
  logic [HEAD_W-1:0]          link_q_r;
  logic [ght_pkg::HALF_W-1:0] ser_byp_r;
  logic [HEAD_W-1:0]          link_byp_r;
  logic                       ser_hit_r;
  logic                       link_hit_r;

  always_ff @(posedge clk) begin
    if (wr_ctl.ser_we) begin
      ser_mem[wr_addr] <= wr_ser;
    end
    if (wr_ctl.link_we) begin
      link_mem[wr_addr] <= wr_link;
    end
  end

  always_ff @(posedge clk) begin
    if (rd_en) begin
      ser_q_r    <= ser_mem[rd_addr];
      link_q_r   <= link_mem[rd_addr];
      ser_byp_r  <= wr_ser;
      link_byp_r <= wr_link;
      ser_hit_r  <= wr_ctl.ser_we && (wr_addr == rd_addr);
      link_hit_r <= wr_ctl.link_we && (wr_addr == rd_addr);
    end
  end

  assign rd_ser  = ser_hit_r ? ser_byp_r : ser_q_r;
  assign rd_link = link_hit_r ? link_byp_r : link_q_r;

endmodule

`default_nettype wire

@@ src/generational_handle_table_core.sv @@
// ----------------------------------------------------------------------------
// generational_handle_table_core
// Handle allocator with a 16-bit generation serial per slot and a LIFO free
// list linked through the slots; add, remove, lookup and clear commands.
// ----------------------------------------------------------------------------
// A new command word can be taken every cycle unless the read stage is held
// by a stalled result. The accepting edge registers the command together
// with the slot's serial and free-list link, read from the slot memories
// through their registered read port; the read stage then checks the handle,
// updates the head, count and memories, and loads the result word into the
// output register. The address for the next read is taken from the head
// value being committed in the same cycle, and a memory write to that same
// address is forwarded, so back-to-back commands never wait on each other.
// A stalled result holds both pipeline stages.
`default_nettype none

module generational_handle_table_core #(
  parameter int unsigned SLOT_COUNT = ght_pkg::SLOT_COUNT_DEF
) (
  input  wire logic             clk,
  input  wire logic             rst_n,
  input  wire logic             in_valid,
  output logic                  in_stall,
  input  wire ght_pkg::ght_in_t in_data,
  output logic                  out_valid,
  input  wire logic             out_stall,
  output ght_pkg::ght_out_t     out_data
);

  localparam int unsigned IDX_W  = $clog2(SLOT_COUNT);
  localparam int unsigned HEAD_W = $clog2(SLOT_COUNT + 1);
  localparam int unsigned HW     = ght_pkg::HALF_W;

  localparam logic [HEAD_W-1:0] EMPTY_HEAD = HEAD_W'(SLOT_COUNT);

  // Table state.
  logic [HEAD_W-1:0] free_head_r, free_head_nxt;
  logic [HEAD_W-1:0] in_use_r, in_use_nxt;

  // Read stage.
  logic              s1_valid_r;
  ght_pkg::ght_cmd_t s1_cmd_r;
  logic [HW-1:0]     s1_idx_r;
  logic [HW-1:0]     s1_ser_r;

  // Output register.
  logic              out_valid_r;
  ght_pkg::ght_out_t out_data_r;

  logic              in_accept;
  logic              s1_fire;
  logic [HW-1:0]     rd_ser;
  logic [HEAD_W-1:0] rd_link;
  logic [HEAD_W-1:0] head_eff;
  logic [IDX_W-1:0]  rd_addr;

  ght_pkg::ght_wr_ctl_t wr_ctl;
  logic [IDX_W-1:0]     wr_addr;
  logic [HW-1:0]        wr_ser;
  ght_pkg::ght_out_t    res;

  logic              in_bounds;
  logic              ser_match;
  logic              list_nonempty;
  logic              room_left;
  logic [IDX_W-1:0]  add_slot;
  logic [HW-1:0]     add_serial;

  assign s1_fire   = s1_valid_r && (!out_valid_r || !out_stall);
  assign in_stall  = s1_valid_r && !s1_fire;
  assign in_accept = in_valid && !in_stall;

  // The head the next command sees is the one being committed this cycle.
  assign head_eff = s1_fire ? free_head_nxt : free_head_r;
  assign rd_addr  = (in_data.command == ght_pkg::CMD_ADD) ? head_eff[IDX_W-1:0]
                                                          : in_data.slot_index[IDX_W-1:0];

  ght_slot_store #(
    .SLOT_COUNT (SLOT_COUNT)
  ) u_store (
    .clk     (clk),
    .rd_en   (in_accept),
    .rd_addr (rd_addr),
    .wr_ctl  (wr_ctl),
    .wr_addr (wr_addr),
    .wr_ser  (wr_ser),
    .wr_link (free_head_r),
    .rd_ser  (rd_ser),
    .rd_link (rd_link)
  );

  assign in_bounds     = s1_idx_r < HW'(in_use_r);
  assign ser_match     = rd_ser == s1_ser_r;
  assign list_nonempty = free_head_r != EMPTY_HEAD;
  assign room_left     = in_use_r != EMPTY_HEAD;
  assign add_slot      = list_nonempty ? free_head_r[IDX_W-1:0] : in_use_r[IDX_W-1:0];
  assign add_serial    = list_nonempty ? rd_ser : HW'(1);

  always_comb begin
    res            = '0;
    res.status     = ght_pkg::ST_OK;
    free_head_nxt  = free_head_r;
    in_use_nxt     = in_use_r;
    wr_ctl         = '0;
    wr_addr        = s1_idx_r[IDX_W-1:0];
    wr_ser         = rd_ser + HW'(1);

    unique case (s1_cmd_r)
      ght_pkg::CMD_ADD: begin
        if (list_nonempty || room_left) begin
          res.handle      = {add_serial, HW'(add_slot)};
          res.result_slot = ght_pkg::RESULT_SLOT_W'(add_slot);
          if (list_nonempty) begin
            free_head_nxt = rd_link;
          end else begin
            // A fresh slot is appended with serial one.
            wr_ctl.ser_we = s1_fire;
            wr_addr       = add_slot;
            wr_ser        = HW'(1);
            in_use_nxt    = in_use_r + HEAD_W'(1);
          end
        end else begin
          res.status = ght_pkg::ST_FULL;
        end
      end
      ght_pkg::CMD_REMOVE: begin
        if (s1_ser_r == '0) begin
          res.status = ght_pkg::ST_OK;
        end else if (!in_bounds) begin
          res.status = ght_pkg::ST_BOUNDS;
        end else if (!ser_match) begin
          res.status = ght_pkg::ST_STALE;
        end else begin
          res.result_slot = ght_pkg::RESULT_SLOT_W'(s1_idx_r);
          wr_ctl.ser_we   = s1_fire;
          wr_ctl.link_we  = s1_fire;
          free_head_nxt   = HEAD_W'(s1_idx_r);
        end
      end
      ght_pkg::CMD_LOOKUP: begin
        if (!in_bounds) begin
          res.status = ght_pkg::ST_BOUNDS;
        end else if (!ser_match) begin
          res.status = ght_pkg::ST_STALE;
        end else begin
          res.result_slot = ght_pkg::RESULT_SLOT_W'(s1_idx_r);
        end
      end
      ght_pkg::CMD_CLEAR: begin
        free_head_nxt = EMPTY_HEAD;
        in_use_nxt    = '0;
      end
      default: begin
        res.status = ght_pkg::ST_OK;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r  <= 1'b0;
      out_valid_r <= 1'b0;
      free_head_r <= EMPTY_HEAD;
      in_use_r    <= '0;
    end else begin
      s1_valid_r  <= in_accept || (s1_valid_r && !s1_fire);
      out_valid_r <= s1_fire || (out_valid_r && out_stall);
      if (s1_fire) begin
        free_head_r <= free_head_nxt;
        in_use_r    <= in_use_nxt;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (in_accept) begin
      s1_cmd_r <= ght_pkg::ght_cmd_t'(in_data.command);
      s1_idx_r <= in_data.slot_index;
      s1_ser_r <= in_data.serial;
    end
    if (s1_fire) begin
      out_data_r <= res;
    end
  end

  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

`ifndef SYNTHESIS
  a_head_range : assert property (@(posedge clk) disable iff (!rst_n)
    (free_head_r <= EMPTY_HEAD) && (in_use_r <= EMPTY_HEAD))
    else $error("free-list head or slot count out of range");

  a_full_only_when_exhausted : assert property (@(posedge clk) disable iff (!rst_n)
    s1_fire && (res.status == ght_pkg::ST_FULL) |->
      (free_head_r == EMPTY_HEAD) && (in_use_r == EMPTY_HEAD))
    else $error("table full reported with slots still available");

  a_fire_loads_output : assert property (@(posedge clk) disable iff (!rst_n)
    s1_fire |=> out_valid_r)
    else $error("result lost on its way to the output register");

  a_remove_pushes_slot : assert property (@(posedge clk) disable iff (!rst_n)
    s1_fire && wr_ctl.link_we |=> free_head_r == HEAD_W'($past(s1_idx_r)))
    else $error("removed slot not placed at the head of the free list");

  a_stall_holds_stage : assert property (@(posedge clk) disable iff (!rst_n)
    in_stall |=> s1_valid_r && $stable(s1_idx_r) && $stable(s1_ser_r))
    else $error("read stage changed while held");
`endif

endmodule

`default_nettype wire
